/* design/adjacent_swap_permutation_generator_macros.svh */
// Assertion macros for the adjacent-swap permutation generator.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ADJACENT_SWAP_PERMUTATION_GENERATOR_MACROS_SVH
`define ADJACENT_SWAP_PERMUTATION_GENERATOR_MACROS_SVH

// Consequence checked in the same cycle.
`define ASP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence checked in the next cycle.
`define ASP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/asp_pkg.sv */
// Shared constants and types for the adjacent-swap permutation generator.
// No dependencies.
package asp_pkg;

    localparam int MAX_ELEMENTS = 8;
    localparam int VAL_W        = $clog2(MAX_ELEMENTS);
    localparam int CFG_W        = 4;
    localparam int OUT_POS      = 8;
    localparam int OUT_VW       = 3;
    localparam int PERM_W       = OUT_POS * OUT_VW;

    typedef struct packed {
        logic             load;
        logic             update;
        logic [VAL_W-1:0] moved;
    } t_cell_ctrl;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } t_max;

endpackage

/* design/asp_cell.sv */
// One position of the permutation: element value, direction mark, local
// mobility test and one link of the largest-mobile chain. Uses asp_pkg.
module asp_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [asp_pkg::VAL_W-1:0] i_pos,
    input  asp_pkg::t_cell_ctrl       i_ctrl,
    input  logic                      i_act,
    input  logic                      i_l_act,
    input  logic [asp_pkg::VAL_W-1:0] i_l_val,
    input  logic                      i_l_dir,
    input  logic                      i_r_act,
    input  logic [asp_pkg::VAL_W-1:0] i_r_val,
    input  logic                      i_r_dir,
    input  asp_pkg::t_max             i_max,
    output asp_pkg::t_max             o_max,
    output logic [asp_pkg::VAL_W-1:0] o_val,
    output logic                      o_dir,
    output logic [asp_pkg::VAL_W-1:0] o_nval,
    output logic                      o_ndir
);
    import asp_pkg::*;

    logic [VAL_W-1:0] r_val, n_val;
    logic             r_dir, n_dir;
    logic             w_mobile;
    logic [VAL_W-1:0] w_sw_val;
    logic             w_sw_dir;

    // mobile: points at an active, smaller neighbor
    assign w_mobile = i_act && (r_dir ? (i_l_act && (i_l_val < r_val))
                                      : (i_r_act && (i_r_val < r_val)));

    always_comb begin
        if (w_mobile && (!i_max.found || (r_val > i_max.value))) begin
            o_max.found = 1'b1;
            o_max.value = r_val;
        end else begin
            o_max = i_max;
        end
    end

    // swap: mover takes its neighbor, target takes the mover
    always_comb begin
        w_sw_val = r_val;
        w_sw_dir = r_dir;
        priority if (i_act && (r_val == i_ctrl.moved)) begin
            w_sw_val = r_dir ? i_l_val : i_r_val;
            w_sw_dir = r_dir ? i_l_dir : i_r_dir;
        end else if (i_l_act && (i_l_val == i_ctrl.moved) && !i_l_dir) begin
            w_sw_val = i_l_val;
            w_sw_dir = i_l_dir;
        end else if (i_r_act && (i_r_val == i_ctrl.moved) && i_r_dir) begin
            w_sw_val = i_r_val;
            w_sw_dir = i_r_dir;
        end else begin
            w_sw_val = r_val;
            w_sw_dir = r_dir;
        end
    end

    always_comb begin
        n_val = r_val;
        n_dir = r_dir;
        priority if (i_ctrl.load) begin
            n_val = i_pos;
            n_dir = 1'b1;
        end else if (i_ctrl.update) begin
            n_val = w_sw_val;
            n_dir = w_sw_dir ^ (i_act && (w_sw_val > i_ctrl.moved));
        end else begin
            n_val = r_val;
            n_dir = r_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= i_pos;
            r_dir <= 1'b1;
        end else begin
            r_val <= n_val;
            r_dir <= n_dir;
        end
    end

    assign o_val  = r_val;
    assign o_dir  = r_dir;
    assign o_nval = n_val;
    assign o_ndir = n_dir;

endmodule

/* design/adjacent_swap_permutation_generator.sv */
// Top level of the adjacent-swap permutation generator: cell row, sequencer,
// output register. Uses asp_pkg, asp_cell and the assertion macro header.

// Steps through permutations in Steinhaus-Johnson-Trotter order. A request
// with i_restart high loads the identity (all elements pointing left); a
// request with i_restart low moves the largest mobile element one place,
// flips every larger element, and returns the new order, or returns the
// order unchanged with o_done_res set when nothing is mobile. Each request
// passes through a search state, in which the largest-mobile value ripples
// along the row of cells and is registered, and then an apply state, in
// which every cell swaps/flips and the result is loaded into the output
// register. A new request can be taken in the apply state while the
// previous one finishes; the apply state waits while a previous result is
// still held in the output register. i_cfg_data sets the element count
// (0 counts as 1, above the row size counts as the row size); write it only
// while no request is in flight. Positions at or beyond the count read as
// zero in o_perm_packed and o_direction_bits.
module adjacent_swap_permutation_generator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [asp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_restart,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [asp_pkg::PERM_W-1:0] o_perm_packed,
    output logic [asp_pkg::OUT_POS-1:0] o_direction_bits,
    output logic                      o_done_res
);
    import asp_pkg::*;

`include "adjacent_swap_permutation_generator_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_APPLY  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CFG_W-1:0] r_n_in_use;
    logic [CFG_W-1:0] w_n_eff;
    logic            r_restart;
    t_max            r_best;
    logic            r_out_valid;
    logic [PERM_W-1:0]  r_perm;
    logic [OUT_POS-1:0] r_dirs;
    logic            r_done;

    logic            w_out_free, w_finish, w_take;
    t_cell_ctrl      w_ctrl;

    logic [VAL_W-1:0] w_val  [MAX_ELEMENTS];
    logic             w_dir  [MAX_ELEMENTS];
    logic [VAL_W-1:0] w_nval [MAX_ELEMENTS];
    logic             w_ndir [MAX_ELEMENTS];
    logic             w_act  [MAX_ELEMENTS];
    t_max             w_max  [MAX_ELEMENTS+1];
    logic [PERM_W-1:0]  w_perm;
    logic [OUT_POS-1:0] w_dirs;

    // element count, clamped; the register itself keeps what was written
    always_comb begin
        priority if (r_n_in_use == '0) begin
            w_n_eff = CFG_W'(1);
        end else if (r_n_in_use > CFG_W'(MAX_ELEMENTS)) begin
            w_n_eff = CFG_W'(MAX_ELEMENTS);
        end else begin
            w_n_eff = r_n_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_in_use <= CFG_W'(8);
        end else if (i_cfg_we) begin
            r_n_in_use <= i_cfg_data;
        end
    end

    // handshake: a new request enters in idle or in the finishing apply cycle
    assign w_out_free = !r_out_valid || i_ready;
    assign w_finish   = (r_state == S_APPLY) && w_out_free;
    assign o_ready    = (r_state == S_IDLE) || w_finish;
    assign w_take     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   n_state = w_take ? S_SEARCH : S_IDLE;
            S_SEARCH: n_state = S_APPLY;
            S_APPLY: begin
                if (w_finish) begin
                    n_state = w_take ? S_SEARCH : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_restart <= i_restart;
        end
        if (r_state == S_SEARCH) begin
            r_best <= w_max[MAX_ELEMENTS];
        end
    end

    assign w_ctrl.load   = w_finish && r_restart;
    assign w_ctrl.update = w_finish && !r_restart && r_best.found;
    assign w_ctrl.moved  = r_best.value;

    // row of cells; the largest-mobile search ripples left to right
    assign w_max[0] = '0;

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic             w_l_act, w_r_act, w_l_dir, w_r_dir;
        logic [VAL_W-1:0] w_l_val, w_r_val;

        assign w_act[g] = (CFG_W'(g) < w_n_eff);

        if (g > 0) begin : g_left
            assign w_l_act = 1'b1;
            assign w_l_val = w_val[g-1];
            assign w_l_dir = w_dir[g-1];
        end else begin : g_left_edge
            assign w_l_act = 1'b0;
            assign w_l_val = '0;
            assign w_l_dir = 1'b0;
        end

        if (g < MAX_ELEMENTS-1) begin : g_right
            assign w_r_act = (CFG_W'(g+1) < w_n_eff);
            assign w_r_val = w_val[g+1];
            assign w_r_dir = w_dir[g+1];
        end else begin : g_right_edge
            assign w_r_act = 1'b0;
            assign w_r_val = '0;
            assign w_r_dir = 1'b0;
        end

        asp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (VAL_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_act   (w_act[g]),
            .i_l_act (w_l_act),
            .i_l_val (w_l_val),
            .i_l_dir (w_l_dir),
            .i_r_act (w_r_act),
            .i_r_val (w_r_val),
            .i_r_dir (w_r_dir),
            .i_max   (w_max[g]),
            .o_max   (w_max[g+1]),
            .o_val   (w_val[g]),
            .o_dir   (w_dir[g]),
            .o_nval  (w_nval[g]),
            .o_ndir  (w_ndir[g])
        );
    end

    // pack the post-update state; positions past the count show zero
    for (genvar g = 0; g < OUT_POS; g++) begin : g_pack
        if (g < MAX_ELEMENTS) begin : g_used
            assign w_perm[g*OUT_VW +: OUT_VW] = w_act[g] ? OUT_VW'(w_nval[g]) : '0;
            assign w_dirs[g] = w_act[g] && w_ndir[g];
        end else begin : g_unused
            assign w_perm[g*OUT_VW +: OUT_VW] = '0;
            assign w_dirs[g] = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_perm <= w_perm;
            r_dirs <= w_dirs;
            r_done <= !r_restart && !r_best.found;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_perm_packed    = r_perm;
    assign o_direction_bits = r_dirs;
    assign o_done_res       = r_done;

    // a taken request always goes to the search cycle
    `ASP_ASSERT_NEXT(a_take_search, w_take, r_state == S_SEARCH)
    // the search cycle is always followed by the apply cycle
    `ASP_ASSERT_NEXT(a_search_apply, r_state == S_SEARCH, r_state == S_APPLY)
    // apply waits while the previous result is held
    `ASP_ASSERT_NEXT(a_apply_stall, (r_state == S_APPLY) && r_out_valid && !i_ready,
                     (r_state == S_APPLY) && o_valid)
    // cells change only on the finishing apply cycle
    `ASP_ASSERT_SAME(a_ctrl_finish, w_ctrl.load || w_ctrl.update,
                     (r_state == S_APPLY) && w_out_free)

endmodule

/* verif/tb.sv */
// Self-checking testbench for the adjacent-swap permutation generator.
// Depends on asp_pkg and the adjacent_swap_permutation_generator RTL;
// results are predicted in-bench and compared in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asp_pkg::*;

    // One result as the block returns it.
    typedef struct packed {
        logic [PERM_W-1:0]  perm;
        logic [OUT_POS-1:0] dirs;
        logic               done;
    } perm_result_t;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                i_cfg_we  = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_valid   = 1'b0;
    logic                o_ready;
    logic                i_restart = 1'b0;
    logic                o_valid;
    logic                i_ready   = 1'b0;
    logic [PERM_W-1:0]   o_perm_packed;
    logic [OUT_POS-1:0]  o_direction_bits;
    logic                o_done_res;

    // Predictor state: order of values, direction per position, element count.
    logic [VAL_W-1:0]    perm_val [MAX_ELEMENTS];
    bit                  points_left [MAX_ELEMENTS];
    logic [CFG_W-1:0]    count_cfg;

    bit                  request_q [$];       // restart flag of each pending request
    perm_result_t        expected_perms [$];  // results owed by the block, oldest first
    int                  mismatch_cnt = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    adjacent_swap_permutation_generator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_restart        (i_restart),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_perm_packed    (o_perm_packed),
        .o_direction_bits (o_direction_bits),
        .o_done_res       (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the run hangs.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Identity order, every element pointing left.
    function automatic void load_identity();
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            perm_val[i]    = VAL_W'(i);
            points_left[i] = 1'b1;
        end
    endfunction

    // Apply one request to the predictor state and return what the block
    // should answer with.
    function automatic perm_result_t step_permutation(input bit restart);
        int               n;
        int               best;
        int               nb;
        logic [VAL_W-1:0] moved;
        logic [VAL_W-1:0] tv;
        bit               td;
        perm_result_t     r;
        // A count of zero acts as one; anything above the row size is clipped.
        n = int'(count_cfg);
        if (n < 1) n = 1;
        if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
        r.done = 1'b0;
        best   = -1;
        if (restart) begin
            load_identity();
        end else begin
            // Largest mobile element: points at a smaller neighbor inside 0..n-1.
            for (int i = 0; i < n; i++) begin
                nb = points_left[i] ? i - 1 : i + 1;
                if (nb >= 0 && nb < n && perm_val[nb] < perm_val[i]) begin
                    if (best < 0 || perm_val[i] > perm_val[best]) best = i;
                end
            end
            if (best < 0) begin
                // Nothing mobile: order stays, done flag goes up.
                r.done = 1'b1;
            end else begin
                nb    = points_left[best] ? best - 1 : best + 1;
                moved = perm_val[best];
                tv    = perm_val[nb];
                td    = points_left[nb];
                perm_val[nb]      = perm_val[best];
                points_left[nb]   = points_left[best];
                perm_val[best]    = tv;
                points_left[best] = td;
                // Every element larger than the one just moved turns around.
                for (int i = 0; i < n; i++) begin
                    if (perm_val[i] > moved) points_left[i] = ~points_left[i];
                end
            end
        end
        // Only positions below the count are shown; the rest read zero.
        r.perm = '0;
        r.dirs = '0;
        for (int i = 0; i < n && i < OUT_POS; i++) begin
            r.perm[OUT_VW*i +: OUT_VW] = OUT_VW'(perm_val[i]);
            r.dirs[i]                  = points_left[i];
        end
        return r;
    endfunction

    // Driver: presents the next pending request once the previous one has
    // been taken, with random gaps. The prediction is made at acceptance.
    always @(posedge i_clk) begin
        bit send_now;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) expected_perms.push_back(step_permutation(i_restart));
            send_now = (request_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (send_now) begin
                i_valid   <= 1'b1;
                i_restart <= request_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, in-order compare of every returned result.
    always @(posedge i_clk) begin
        perm_result_t want;
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_valid && i_ready) begin
                if (expected_perms.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: perm=%h dirs=%h done=%b",
                                 o_perm_packed, o_direction_bits, o_done_res);
                end else begin
                    want = expected_perms.pop_front();
                    if (want.perm !== o_perm_packed || want.dirs !== o_direction_bits ||
                        want.done !== o_done_res) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: perm exp=%h got=%h dirs exp=%h got=%h done exp=%b got=%b",
                                     want.perm, o_perm_packed, want.dirs, o_direction_bits,
                                     want.done, o_done_res);
                    end
                end
            end
        end
    end

    task automatic push_req(input bit restart, input int cnt);
        for (int i = 0; i < cnt; i++) request_q.push_back(restart);
    endtask

    // Wait until nothing is queued, in flight or owed.
    task automatic wait_idle();
        while (request_q.size() != 0 || i_valid || expected_perms.size() != 0)
            @(posedge i_clk);
    endtask

    // Count register write, only once the block has drained.
    task automatic write_count(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        count_cfg   = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic for one count setting. Mostly restart followed by a run
    // of advances (sometimes long enough to hit done for small counts), plus loose
    // single requests and advances with no restart in front.
    task automatic queue_sequences(input int total);
        int n;
        int pushed;
        int span;
        int k;
        int pick;
        n = int'(count_cfg);
        if (n < 1) n = 1;
        if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
        // Carry on with the order left by the previous count.
        k = $urandom_range(1, 4);
        push_req(1'b0, k);
        pushed = k;
        while (pushed < total) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                span = 40;
                if (n <= 5) begin
                    span = 1;
                    for (int i = 2; i <= n; i++) span *= i;
                    span += 2;
                    // Full walk for five elements only now and then.
                    if (n == 5 && $urandom_range(99) >= 15) span = 40;
                end
                k = $urandom_range(0, span);
                push_req(1'b1, 1);
                push_req(1'b0, k);
                pushed += k + 1;
            end else if (pick < 92) begin
                push_req(bit'($urandom_range(1)), 1);
                pushed++;
            end else begin
                k = $urandom_range(1, 6);
                push_req(1'b0, k);
                pushed += k;
            end
        end
    endtask

    initial begin
        load_identity();
        count_cfg = CFG_W'(MAX_ELEMENTS);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        send_idle_pct = 9;
        recv_idle_pct = 75;
        // Advances straight out of reset, then a restart.
        push_req(1'b0, 3);
        push_req(1'b1, 1);
        push_req(1'b0, 1);
        // Count shrinks mid-sequence with no restart.
        write_count(4'd3);
        push_req(1'b0, 2);
        // Full three-element walk, done, and one more advance after done.
        push_req(1'b1, 1);
        push_req(1'b0, 7);
        // Single element never moves.
        write_count(4'd1);
        push_req(1'b0, 1);
        push_req(1'b1, 1);
        push_req(1'b0, 1);
        // Zero counts as one.
        write_count(4'd0);
        push_req(1'b0, 1);
        push_req(1'b1, 1);
        // Oversized count is clipped to the row size.
        write_count(4'd15);
        push_req(1'b1, 1);
        push_req(1'b0, 1);
        // Two elements: one swap, then done.
        write_count(4'd2);
        push_req(1'b1, 1);
        push_req(1'b0, 3);

        // ---- random part: sender mostly busy, receiver mostly stalling ----
        write_count(4'd4);
        queue_sequences(110);
        write_count(4'd5);
        queue_sequences(150);
        write_count(4'd8);
        queue_sequences(100);

        // Sender mostly idle, receiver mostly ready. The wait below holds the
        // sender until all results are back.
        wait_idle();
        send_idle_pct = 75;
        recv_idle_pct = 9;
        write_count(4'd3);
        queue_sequences(90);
        write_count(4'd7);
        queue_sequences(100);
        write_count(4'd15);
        queue_sequences(80);

        // Full rate both ways.
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_count(4'd2);
        queue_sequences(60);
        write_count(4'd6);
        queue_sequences(120);
        write_count(4'd0);
        queue_sequences(30);
        write_count(4'd9);
        queue_sequences(40);
        write_count(4'd5);
        queue_sequences(70);

        // Drain, then give stray results a chance to show up.
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_perms.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
